[rtl/sliding_window_gather_address_top_macros.svh]
// Assertion macros for the sliding-window gather address block.
// Used by files that check their own logic; expects clk and rst in scope.
`ifndef SLIDING_WINDOW_GATHER_ADDRESS_TOP_MACROS_SVH
`define SLIDING_WINDOW_GATHER_ADDRESS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SWGA_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
`define SWGA_IMPLIES_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`else
`define SWGA_IMPLIES(label, a, b)
`define SWGA_IMPLIES_NEXT(label, a, b)
`endif
`endif

[rtl/swg_pkg.sv]
// Shared types and constants for the sliding-window gather address block.
// No dependencies.
`default_nettype none
package swg_pkg;
  localparam int NUM_REGS  = 8;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int REG_BITS  = 16;

  localparam logic [2:0] REG_WIN_SIZE_OUTER   = 3'd0;
  localparam logic [2:0] REG_WIN_SIZE_MID     = 3'd1;
  localparam logic [2:0] REG_WIN_SIZE_INNER   = 3'd2;
  localparam logic [2:0] REG_STRIDE_OUTER     = 3'd3;
  localparam logic [2:0] REG_STRIDE_MID       = 3'd4;
  localparam logic [2:0] REG_STRIDE_INNER     = 3'd5;
  localparam logic [2:0] REG_SRC_EXTENT_MID   = 3'd6;
  localparam logic [2:0] REG_SRC_EXTENT_INNER = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_DIV_INNER = 5'b00010,
    ST_DIV_MID   = 5'b00100,
    ST_MUL_A     = 5'b01000,
    ST_MUL_B     = 5'b10000
  } setup_state_t;

  typedef struct packed {
    logic en;
    logic vld;
  } cell_ctl_t;
endpackage
`default_nettype wire

[rtl/sliding_window_gather_address_top.sv]
// Sliding-window gather address generator, top level.
// Depends on swg_pkg, swg_setup, swg_level and the assertion macros.
//
// Usage: write the eight window registers over the APB-style port while
// the block is idle, then stream output indices in on in_valid/in_ready.
// Each accepted word returns one source_index on out_valid/out_ready,
// in order. Each word passes through three chains of INDEX_BITS division
// cells, one quotient bit per cell (window number, outer coordinates,
// middle and inner coordinates), then multiply, multiply and sum stages.
// Throughput is one word per cycle unless setup is busy or the output stalls.
// After reset and after every register write the setup sequencer derives
// window counts and strides through its bit-serial divider; in_ready stays
// low meanwhile.
// Reset loads every register with 1 and empties the pipeline.
// When the receiver stalls the whole pipeline holds; words in flight keep
// their place and the output word stays stable until taken.
`default_nettype none
`include "sliding_window_gather_address_top_macros.svh"
module sliding_window_gather_address_top #(
  parameter int DIMS        = 3,
  parameter int INDEX_BITS  = 32,
  parameter int EXTENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swg_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [swg_pkg::DATA_BITS-1:0]  pwdata,
  output logic [swg_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [INDEX_BITS-1:0]          out_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [INDEX_BITS-1:0]          source_index
);
  import swg_pkg::*;

  localparam int IW = INDEX_BITS;
  localparam int EB = EXTENT_BITS;
  localparam int RB = (EB < REG_BITS) ? EB : REG_BITS;

  logic [RB-1:0] cfg [NUM_REGS];
  logic [EB-1:0] eff [NUM_REGS];
  logic          cfg_wr, en, busy;
  logic [IW:0]   wci, wstr0, rstr0, win_total;
  logic [IW-1:0] pstr0;
  cell_ctl_t     c1, c2, c3;

  logic            l1_vld, l2_vld, l3_vld;
  logic [IW-1:0]   l1_qa, l1_ra, l1_qb, l1_rb;
  logic [IW-1:0]   l2_qa, l2_ra, l2_qb, l2_rb;
  logic [IW-1:0]   l3_qa, l3_ra, l3_qb, l3_rb;
  logic [2*IW-1:0] l1_keep, l2_keep, l3_keep;
  logic [IW-1:0]   wc0, rc0;
  logic            s1_vld, s2_vld;
  logic [IW-1:0]   a0, a1, a2, t0, t1, t2;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = DATA_BITS'(cfg[paddr[4:2]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        cfg[k] <= RB'(1);
      end
    end else if (cfg_wr) begin
      cfg[paddr[4:2]] <= pwdata[RB-1:0];
    end
  end

  // a zero register counts as one
  for (genvar k = 0; k < NUM_REGS; k++) begin : g_eff
    assign eff[k] = (cfg[k] == '0) ? EB'(1) : EB'(cfg[k]);
  end

  swg_setup #(.DIMS(DIMS), .IW(IW), .EB(EB)) u_setup (
    .clk(clk), .rst(rst), .start(cfg_wr),
    .size0(eff[REG_WIN_SIZE_OUTER]), .size1(eff[REG_WIN_SIZE_MID]),
    .size2(eff[REG_WIN_SIZE_INNER]), .step1(eff[REG_STRIDE_MID]),
    .step2(eff[REG_STRIDE_INNER]), .ext_m(eff[REG_SRC_EXTENT_MID]),
    .ext_i(eff[REG_SRC_EXTENT_INNER]),
    .busy(busy), .wci(wci), .wstr0(wstr0), .rstr0(rstr0),
    .win_total(win_total), .pstr0(pstr0)
  );

  // advance everything unless the output word is stuck
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !busy;

  assign c1 = '{en: en, vld: in_valid && !busy};
  assign c2 = '{en: en, vld: l1_vld};
  assign c3 = '{en: en, vld: l2_vld};

  // window number and position inside the window
  swg_level #(.IW(IW)) u_lvl_win (
    .clk(clk), .rst(rst), .ctl(c1), .div_a(win_total), .div_b((IW+1)'(1)),
    .num_a(out_index), .num_b('0), .keep_in('0),
    .vld(l1_vld), .quo_a(l1_qa), .rem_a(l1_ra), .quo_b(l1_qb), .rem_b(l1_rb),
    .keep_out(l1_keep)
  );

  // outermost coordinates
  swg_level #(.IW(IW)) u_lvl_outer (
    .clk(clk), .rst(rst), .ctl(c2), .div_a(wstr0), .div_b(rstr0),
    .num_a(l1_qa), .num_b(l1_ra), .keep_in('0),
    .vld(l2_vld), .quo_a(l2_qa), .rem_a(l2_ra), .quo_b(l2_qb), .rem_b(l2_rb),
    .keep_out(l2_keep)
  );

  // middle and inner coordinates; carry the outer ones alongside
  swg_level #(.IW(IW)) u_lvl_inner (
    .clk(clk), .rst(rst), .ctl(c3), .div_a(wci),
    .div_b((IW+1)'(eff[REG_WIN_SIZE_INNER])),
    .num_a(l2_ra), .num_b(l2_rb), .keep_in({l2_qa, l2_qb}),
    .vld(l3_vld), .quo_a(l3_qa), .rem_a(l3_ra), .quo_b(l3_qb), .rem_b(l3_rb),
    .keep_out(l3_keep)
  );

  assign wc0 = l3_keep[2*IW-1:IW];
  assign rc0 = l3_keep[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_vld    <= l3_vld;
      s2_vld    <= s1_vld;
      out_valid <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // window corner plus offset, per dimension
      a0 <= wc0 * IW'(eff[REG_STRIDE_OUTER]) + rc0;
      a1 <= l3_qa * IW'(eff[REG_STRIDE_MID]) + l3_qb;
      a2 <= l3_ra * IW'(eff[REG_STRIDE_INNER]) + l3_rb;
      t0 <= a0 * pstr0;
      t1 <= a1 * IW'(eff[REG_SRC_EXTENT_INNER]);
      t2 <= a2;
      source_index <= t0 + t1 + t2;
    end
  end

  `SWGA_IMPLIES_NEXT(a_cfg_restarts_setup, cfg_wr, busy)
  `SWGA_IMPLIES(a_busy_blocks_input, busy, !in_ready)
  `SWGA_IMPLIES(a_divisors_nonzero, !busy,
    wci != '0 && wstr0 != '0 && rstr0 != '0 && win_total != '0)
  `SWGA_IMPLIES(a_idle_lanes_clear, l1_vld,
    l1_qb == '0 && l1_rb == '0 && l1_keep == '0 && l2_keep == '0)
endmodule
`default_nettype wire

[rtl/swg_cell.sv]
// One restoring-division cell: one quotient bit for each of two lanes.
// Depends on swg_pkg.
`default_nettype none
module swg_cell #(
  parameter int IW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swg_pkg::cell_ctl_t   ctl,
  input  logic [IW:0]          div_a,
  input  logic [IW:0]          div_b,
  input  logic [IW-1:0]        num_a_in,
  input  logic [IW-1:0]        q_a_in,
  input  logic [IW:0]          rem_a_in,
  input  logic [IW-1:0]        num_b_in,
  input  logic [IW-1:0]        q_b_in,
  input  logic [IW:0]          rem_b_in,
  input  logic [2*IW-1:0]      keep_in,
  output logic                 vld_out,
  output logic [IW-1:0]        num_a_out,
  output logic [IW-1:0]        q_a_out,
  output logic [IW:0]          rem_a_out,
  output logic [IW-1:0]        num_b_out,
  output logic [IW-1:0]        q_b_out,
  output logic [IW:0]          rem_b_out,
  output logic [2*IW-1:0]      keep_out
);
  import swg_pkg::*;

  logic [IW+1:0] sh_a, sh_b, dif_a, dif_b;
  logic          ge_a, ge_b;

  // bring down the next numerator bit and try the subtract
  assign sh_a  = {rem_a_in, num_a_in[IW-1]};
  assign sh_b  = {rem_b_in, num_b_in[IW-1]};
  assign dif_a = sh_a - {1'b0, div_a};
  assign dif_b = sh_b - {1'b0, div_b};
  assign ge_a  = sh_a >= {1'b0, div_a};
  assign ge_b  = sh_b >= {1'b0, div_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (ctl.en) begin
      vld_out <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      num_a_out <= num_a_in << 1;
      num_b_out <= num_b_in << 1;
      q_a_out   <= {q_a_in[IW-2:0], ge_a};
      q_b_out   <= {q_b_in[IW-2:0], ge_b};
      rem_a_out <= ge_a ? dif_a[IW:0] : sh_a[IW:0];
      rem_b_out <= ge_b ? dif_b[IW:0] : sh_b[IW:0];
      keep_out  <= keep_in;
    end
  end
endmodule
`default_nettype wire

[rtl/swg_level.sv]
// A chain of IW division cells: full quotient and remainder of two lanes.
// Depends on swg_pkg and swg_cell.
`default_nettype none
module swg_level #(
  parameter int IW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  swg_pkg::cell_ctl_t ctl,
  input  logic [IW:0]        div_a,
  input  logic [IW:0]        div_b,
  input  logic [IW-1:0]      num_a,
  input  logic [IW-1:0]      num_b,
  input  logic [2*IW-1:0]    keep_in,
  output logic               vld,
  output logic [IW-1:0]      quo_a,
  output logic [IW-1:0]      rem_a,
  output logic [IW-1:0]      quo_b,
  output logic [IW-1:0]      rem_b,
  output logic [2*IW-1:0]    keep_out
);
  import swg_pkg::*;

  logic              v   [IW+1];
  logic [IW-1:0]     na  [IW+1];
  logic [IW-1:0]     qa  [IW+1];
  logic [IW:0]       ra  [IW+1];
  logic [IW-1:0]     nb  [IW+1];
  logic [IW-1:0]     qb  [IW+1];
  logic [IW:0]       rb  [IW+1];
  logic [2*IW-1:0]   kp  [IW+1];

  assign v[0]  = ctl.vld;
  assign na[0] = num_a;
  assign nb[0] = num_b;
  assign qa[0] = '0;
  assign qb[0] = '0;
  assign ra[0] = '0;
  assign rb[0] = '0;
  assign kp[0] = keep_in;

  for (genvar k = 0; k < IW; k++) begin : g_cell
    cell_ctl_t cc;
    assign cc = '{en: ctl.en, vld: v[k]};
    swg_cell #(.IW(IW)) u_cell (
      .clk(clk), .rst(rst), .ctl(cc), .div_a(div_a), .div_b(div_b),
      .num_a_in(na[k]), .q_a_in(qa[k]), .rem_a_in(ra[k]),
      .num_b_in(nb[k]), .q_b_in(qb[k]), .rem_b_in(rb[k]), .keep_in(kp[k]),
      .vld_out(v[k+1]),
      .num_a_out(na[k+1]), .q_a_out(qa[k+1]), .rem_a_out(ra[k+1]),
      .num_b_out(nb[k+1]), .q_b_out(qb[k+1]), .rem_b_out(rb[k+1]),
      .keep_out(kp[k+1])
    );
  end

  // remainder is below the divisor and the divisor at most 2^IW
  assign vld      = v[IW];
  assign quo_a    = qa[IW];
  assign quo_b    = qb[IW];
  assign rem_a    = ra[IW][IW-1:0];
  assign rem_b    = rb[IW][IW-1:0];
  assign keep_out = kp[IW];
endmodule
`default_nettype wire

[rtl/swg_setup.sv]
// Sequencer that derives window counts and strides from the registers.
// Depends on swg_pkg; one shared bit-serial divider and several multipliers.
`default_nettype none
module swg_setup #(
  parameter int DIMS = 3,
  parameter int IW   = 32,
  parameter int EB   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [EB-1:0] size0,
  input  logic [EB-1:0] size1,
  input  logic [EB-1:0] size2,
  input  logic [EB-1:0] step1,
  input  logic [EB-1:0] step2,
  input  logic [EB-1:0] ext_m,
  input  logic [EB-1:0] ext_i,
  output logic          busy,
  output logic [IW:0]   wci,
  output logic [IW:0]   wstr0,
  output logic [IW:0]   rstr0,
  output logic [IW:0]   win_total,
  output logic [IW-1:0] pstr0
);
  import swg_pkg::*;

  localparam int NW = EB + 1;
  localparam int CW = $clog2(NW);
  localparam int PW = 3 * EB;
  localparam int SW = (PW > IW + 1) ? PW : IW + 1;
  localparam logic [SW-1:0] LIM = SW'(1) << IW;

  setup_state_t  st;
  logic          load;
  logic [NW-1:0] dnum, drem, dq, den;
  logic [CW-1:0] cnt;
  logic [EB-1:0] wci_r, wcm_r;
  logic [EB-1:0] size0_e, size1_e;
  logic [2*EB-1:0] prod_w, prod_s, prod_p;
  logic [NW-1:0] num_i, num_m;
  logic [NW:0]   sh, dif;
  logic          ge;
  logic [NW-1:0] quo;
  logic [PW-1:0] win_full;

  function automatic logic [IW:0] sat(input logic [SW-1:0] x);
    return (x >= LIM) ? LIM[IW:0] : x[IW:0];
  endfunction

  assign size0_e = (DIMS == 3) ? size0 : EB'(1);
  assign size1_e = (DIMS >= 2) ? size1 : EB'(1);

  // ceil((ext - size + 1) / step) as (ext - size + step) / step
  assign num_i = (size2 > ext_i) ? NW'(step2) : NW'(ext_i) - NW'(size2) + NW'(step2);
  assign num_m = (size1 > ext_m) ? NW'(step1) : NW'(ext_m) - NW'(size1) + NW'(step1);

  assign sh  = {drem, dnum[NW-1]};
  assign dif = sh - {1'b0, den};
  assign ge  = sh >= {1'b0, den};
  assign quo = {dq[NW-2:0], ge};

  assign win_full = PW'(prod_s) * PW'(size0_e);
  assign busy     = load || (st != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      // pass through the load state so the divider sees the updated registers
      st   <= ST_IDLE;
      load <= 1'b1;
    end else if (load) begin
      load <= 1'b0;
      st   <= ST_DIV_INNER;
      cnt  <= '0;
      dnum <= num_i;
      drem <= '0;
      den  <= NW'(step2);
    end else begin
      unique case (st)
        ST_DIV_INNER, ST_DIV_MID: begin
          dnum <= dnum << 1;
          drem <= ge ? dif[NW-1:0] : sh[NW-1:0];
          dq   <= quo;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(NW - 1)) begin
            cnt <= '0;
            if (st == ST_DIV_INNER) begin
              wci_r <= quo[EB-1:0];
              st    <= ST_DIV_MID;
              dnum  <= num_m;
              drem  <= '0;
              den   <= NW'(step1);
            end else begin
              wcm_r <= quo[EB-1:0];
              st    <= ST_MUL_A;
            end
          end
        end
        ST_MUL_A: begin
          prod_w <= wci_r * wcm_r;
          prod_s <= size2 * size1_e;
          prod_p <= ext_i * ext_m;
          st     <= ST_MUL_B;
        end
        ST_MUL_B: begin
          win_total <= sat(SW'(win_full));
          rstr0     <= sat(SW'(prod_s));
          wstr0     <= (DIMS == 3) ? sat(SW'(prod_w)) : LIM[IW:0];
          wci       <= (DIMS >= 2) ? (IW+1)'(wci_r) : LIM[IW:0];
          pstr0     <= IW'(prod_p);
          st        <= ST_IDLE;
        end
        ST_IDLE: begin
          st <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[verif/sliding_window_gather_address_checker.sv]
// Checker for the sliding-window gather address block: watches the APB
// register writes and both word channels, predicts source indices and compares.
// Depends on swg_pkg only.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_gather_address_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [swg_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [swg_pkg::DATA_BITS-1:0] pwdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] out_index,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] source_index,
  output int               fail_count,
  output int               pending
);
  import swg_pkg::*;

  logic [15:0] win_regs [NUM_REGS];
  logic [31:0] expected_addr_q [$];

  assign pending = expected_addr_q.size();

  function automatic longint unsigned nz(logic [15:0] v);
    return (v == 16'd0) ? 64'd1 : {48'd0, v};
  endfunction

  function automatic longint unsigned win_count(longint unsigned ext, longint unsigned sz,
                                                longint unsigned st);
    if (sz > ext) return 1;
    return (ext - sz + 1 + st - 1) / st;
  endfunction

  function automatic logic [31:0] gather_addr(logic [31:0] idx);
    longint unsigned sz [3], st [3], ps [3], rs [3], ws [3];
    longint unsigned wi, rest, addr, wc, rc;
    sz[0] = nz(win_regs[REG_WIN_SIZE_OUTER]);
    sz[1] = nz(win_regs[REG_WIN_SIZE_MID]);
    sz[2] = nz(win_regs[REG_WIN_SIZE_INNER]);
    st[0] = nz(win_regs[REG_STRIDE_OUTER]);
    st[1] = nz(win_regs[REG_STRIDE_MID]);
    st[2] = nz(win_regs[REG_STRIDE_INNER]);
    ps[2] = 1;
    ps[1] = nz(win_regs[REG_SRC_EXTENT_INNER]);
    ps[0] = ps[1] * nz(win_regs[REG_SRC_EXTENT_MID]);
    rs[2] = 1;
    rs[1] = sz[2];
    rs[0] = sz[2] * sz[1];
    ws[2] = 1;
    ws[1] = win_count(ps[1], sz[2], st[2]);
    ws[0] = ws[1] * win_count(nz(win_regs[REG_SRC_EXTENT_MID]), sz[1], st[1]);
    wi = {32'd0, idx} / (rs[0] * sz[0]);
    rest = {32'd0, idx} % (rs[0] * sz[0]);
    addr = 0;
    for (int d = 0; d < 3; d++) begin
      wc = wi / ws[d];
      rc = rest / rs[d];
      addr += wc * st[d] * ps[d] + rc * ps[d];
      wi %= ws[d];
      rest %= rs[d];
    end
    return addr[31:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) win_regs[k] <= 16'd1;
      expected_addr_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[4:2] < NUM_REGS)
        win_regs[paddr[4:2]] <= pwdata[15:0];
      if (in_valid && in_ready) expected_addr_q = {expected_addr_q, gather_addr(out_index)};
      if (out_valid && out_ready) begin
        if (expected_addr_q.size() == 0) begin
          $error("source_index: unexpected word, actual %h", source_index);
          fail_count <= fail_count + 1;
        end else begin
          if (source_index !== expected_addr_q[0]) begin
            $error("source_index: expected %h actual %h", expected_addr_q[0], source_index);
            fail_count <= fail_count + 1;
          end
          void'(expected_addr_q.pop_front());
        end
      end
    end
  end
endmodule
`default_nettype wire

[verif/sliding_window_gather_address_top_test.sv]
// Testbench top for the sliding-window gather address block: drives register
// settings and index words, and gives the verdict. Depends on swg_pkg,
// the block and sliding_window_gather_address_checker.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_gather_address_top_test;
  import swg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0, in_ready;
  logic [31:0] out_index = '0;
  logic        out_valid, out_ready = 1'b0;
  logic [31:0] source_index;
  int          fail_count, pending;
  int          idle_cycles;
  bit          stall_long;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_window_gather_address_top dut (.*);

  sliding_window_gather_address_checker checker_i (.*);

  // Hold off the receiver at random: mostly briefly, but often in every fourth phase.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if ($urandom_range(0, 99) < (stall_long ? 20 : 75)) out_ready <= 1'b1;
    else out_ready <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] reg_idx, logic [15:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {reg_idx, 2'b00}; pwdata <= {16'($urandom_range(0, 65535)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Keep valid high between back-to-back words; drop it only for a gap.
  task automatic send_index(logic [31:0] idx, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    out_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_field(int mode);
    case (mode)
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
           ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  initial begin
    logic [31:0] idx;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Reset setting, directed extremes of the index.
    send_index(32'd0, 0);
    send_index(32'hFFFF_FFFF, 0);
    send_index(32'h8000_0000, 0);
    send_index(32'd1, 1);
    drain();
    // Phases: extremes of every register, windows larger than the extents, then small random shapes.
    for (int phase = 0; phase < 14; phase++) begin
      stall_long = phase % 4 == 3;
      for (int r = 0; r < NUM_REGS; r++) begin
        if (phase < 3) write_reg(r[2:0], pick_field(phase));
        else if (phase == 3) write_reg(r[2:0], (r < 6) ? 16'd3 : 16'd2); // window > extent
        else write_reg(r[2:0], pick_field(3 + (($urandom_range(0, 9) == 0) ? -2 : 0)));
      end
      for (int n = 0; n < ((phase < 4) ? 12 : 105); n++) begin
        case ($urandom_range(0, 3))
          0: idx = $urandom();
          1: idx = ~$urandom_range(0, 300);
          default: idx = $urandom_range(0, 2000);
        endcase
        send_index(idx, pick_gap());
      end
      drain();
      repeat (10) @(posedge clk);
    end
    drain();
    repeat (120) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
